/* rtl/c8core_pkg.sv */
// c8core_pkg: shared types and constants for the CHIP-8 core.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package c8core_pkg;

  localparam int MEM_BYTES_DEF     = 4096;
  localparam int SCREEN_WIDTH_DEF  = 64;
  localparam int SCREEN_HEIGHT_DEF = 32;
  localparam int STACK_DEPTH_DEF   = 16;
  localparam int KEY_TOTAL_DEF     = 16;

  localparam logic [11:0] FONT_BASE_RST = 12'd80;
  localparam logic [7:0]  SEED_RST      = 8'd1;
  localparam logic [11:0] PC_RST        = 12'd512;
  localparam logic [7:0]  LFSR_TAPS     = 8'hB8;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_EXEC  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [0:0] REG_FONT_BASE = 1'd0;
  localparam logic [0:0] REG_SEED      = 1'd1;

  localparam logic [11:0] OP_CLS = 12'h0E0;
  localparam logic [11:0] OP_RET = 12'h0EE;
  localparam logic [7:0] FX_GET_DELAY = 8'h07;
  localparam logic [7:0] FX_KEY_WAIT  = 8'h0A;
  localparam logic [7:0] FX_SET_DELAY = 8'h15;
  localparam logic [7:0] FX_SET_SOUND = 8'h18;
  localparam logic [7:0] FX_ADD_I     = 8'h1E;
  localparam logic [7:0] FX_FONT      = 8'h29;
  localparam logic [7:0] FX_BCD       = 8'h33;
  localparam logic [7:0] FX_STORE     = 8'h55;
  localparam logic [7:0] FX_LOAD      = 8'h65;
  localparam logic [7:0] EX_SKIP_DOWN = 8'h9E;
  localparam logic [7:0] EX_SKIP_UP   = 8'hA1;
  localparam logic [7:0] VF_FLAG_BIT  = 8'h80;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH_HI, ST_FETCH_LO, ST_DECODE, ST_DISPATCH, ST_MEM_RD, ST_MEM_USE,
    ST_DRAW_WR, ST_CLEAR, ST_MEM_WR, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MOP_NONE, MOP_DRAW, MOP_LOAD, MOP_STORE, MOP_BCD, MOP_CLEAR
  } mop_t;

  // controller to datapath
  typedef struct packed {
    logic fetch_hi;
    logic fetch_lo;
    logic decode;
    logic mem_rd;
    logic mem_use;
    logic draw_wr;
    logic clear_step;
    logic mem_wr;
    logic finish;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    mop_t mop;
    logic last;
  } dp_status_t;

endpackage

/* rtl/c8core_ctrl.sv */
// c8core_ctrl: sequencer for fetch, decode and multi-beat memory walks.
// Depends on c8core_pkg.
`timescale 1ns / 1ps
module c8core_ctrl import c8core_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       go_exec,
  input  logic       go_simple,
  input  dp_status_t status,
  output ctl_cmd_t   cmd,
  output logic       busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (go_exec) state_next = ST_FETCH_HI;
        else if (go_simple) state_next = ST_DONE;
      end
      ST_FETCH_HI: state_next = ST_FETCH_LO;
      ST_FETCH_LO: state_next = ST_DECODE;
      ST_DECODE: state_next = ST_DISPATCH;
      // memory op class is registered at the end of decode
      ST_DISPATCH: begin
        unique case (status.mop)
          MOP_NONE:  state_next = ST_DONE;
          MOP_CLEAR: state_next = ST_CLEAR;
          MOP_BCD, MOP_STORE: state_next = ST_MEM_WR;
          default:   state_next = ST_MEM_RD;
        endcase
      end
      ST_MEM_RD: state_next = ST_MEM_USE;
      ST_MEM_USE: state_next = (status.mop == MOP_DRAW) ? ST_DRAW_WR
                               : (status.last ? ST_DONE : ST_MEM_RD);
      ST_DRAW_WR: state_next = status.last ? ST_DONE : ST_MEM_RD;
      ST_CLEAR: state_next = status.last ? ST_DONE : ST_CLEAR;
      ST_MEM_WR: state_next = status.last ? ST_DONE : ST_MEM_WR;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_FETCH_HI: cmd.fetch_hi = 1'b1;
      ST_FETCH_LO: cmd.fetch_lo = 1'b1;
      ST_DECODE:   cmd.decode = 1'b1;
      ST_MEM_RD:   cmd.mem_rd = 1'b1;
      ST_MEM_USE:  cmd.mem_use = 1'b1;
      ST_DRAW_WR:  cmd.draw_wr = 1'b1;
      ST_CLEAR:    cmd.clear_step = 1'b1;
      ST_MEM_WR:   cmd.mem_wr = 1'b1;
      ST_DONE:     cmd.finish = 1'b1;
      default: ;
    endcase
  end

endmodule

/* rtl/c8core_dp.sv */
// c8core_dp: registers, main memory, frame memory, stack and result register.
// Depends on c8core_pkg; sequenced by c8core_ctrl.
`timescale 1ns / 1ps
module c8core_dp import c8core_pkg::*; #(
  parameter int MEM_BYTES     = MEM_BYTES_DEF,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  command,
  input  logic [11:0] address,
  input  logic [7:0]  data,
  input  logic [4:0]  row_index,
  input  logic [15:0] key_mask,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  ctl_cmd_t    cmd,
  output dp_status_t  status,
  output logic [11:0] program_counter,
  output logic [SCREEN_WIDTH-1:0] row_pixels,
  output logic        display_changed,
  output logic        waiting_for_key,
  output logic [7:0]  delay_value,
  output logic [7:0]  sound_value,
  output logic        stack_fault
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int RW = $clog2(SCREEN_HEIGHT);
  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [7:0] mem [MEM_BYTES];
  logic [SCREEN_WIDTH-1:0] frame [SCREEN_HEIGHT];
  logic [11:0] rstack [STACK_DEPTH];
  logic [7:0] v [16];
  logic [SCREEN_HEIGHT-1:0] row_ok;   // row valid bits; invalid reads as clear

  logic [11:0] font_base, ireg, pc;
  logic [7:0]  seed, lfsr, dt, st;
  logic [SW-1:0] sp;
  logic [1:0]  cmd_q;
  logic [4:0]  row_q;
  logic [15:0] keys_q;
  logic [15:0] op;
  mop_t        mop;
  logic [3:0]  cnt, cnt_end;
  logic [7:0]  mem_q;
  logic [SCREEN_WIDTH-1:0] frame_q;
  logic        row_ok_q;
  logic [SCREEN_WIDTH-1:0] spr_mask;
  logic        hit, changed, waiting, fault;
  logic [7:0]  bcd [3];

  logic [3:0] ox, oy;
  logic [7:0] nn, vx, vy;
  logic [11:0] nnn, pc2, pc4;
  assign ox = op[11:8];
  assign oy = op[7:4];
  assign nn = op[7:0];
  assign nnn = op[11:0];
  assign vx = v[ox];
  assign vy = v[oy];
  assign pc2 = pc + 12'd2;
  assign pc4 = pc + 12'd4;

  logic [11:0] maddr;
  logic [AW-1:0] mrd;
  logic [RW-1:0] frow;
  logic [11:0] frow_full;
  assign maddr = ireg + {8'd0, cnt};
  always_comb begin
    if (cmd.fetch_hi) mrd = pc[AW-1:0];
    else if (cmd.fetch_lo) mrd = pc2[AW-1:0] - AW'(1);
    else mrd = maddr[AW-1:0];
  end
  assign frow_full = (12'(vy) + {8'd0, cnt}) % 12'(SCREEN_HEIGHT);
  assign frow = cmd.clear_step ? cnt[RW-1:0] : frow_full[RW-1:0];

  assign status.mop = mop;
  assign status.last = (cnt == cnt_end);

  // sprite mask for the current byte, wrapping at the right edge
  always_comb begin
    logic [11:0] px;
    spr_mask = '0;
    for (int c = 0; c < 8; c++) begin
      px = (12'(vx) + 12'(c)) % 12'(SCREEN_WIDTH);
      if (mem_q[7-c]) spr_mask[SCREEN_WIDTH-1-px[XW-1:0]] = 1'b1;
    end
  end

  logic [7:0] lfsr_step;
  assign lfsr_step = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);

  logic [4:0] key_low;
  always_comb begin
    key_low = 5'd16;
    for (int k = 15; k >= 0; k--) if (keys_q[k]) key_low = 5'(k);
  end

  // memory port: one write, one registered read
  always_ff @(posedge clk) begin
    if (accept && command == CMD_WRITE) mem[address[AW-1:0]] <= data;
    else if (cmd.mem_wr) mem[maddr[AW-1:0]] <= (mop == MOP_BCD) ? bcd[cnt[1:0]] : v[cnt];
    mem_q <= mem[mrd];
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_wr) frame[frow] <= (row_ok_q ? frame_q : '0) ^ spr_mask;
    frame_q <= frame[accept ? row_index[RW-1:0] : frow];
    row_ok_q <= row_ok[accept ? row_index[RW-1:0] : frow];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      row_q <= row_index;
      keys_q <= key_mask;
    end
    if (cmd.fetch_lo) op[15:8] <= mem_q;
    if (cmd.decode) op[7:0] <= mem_q;
  end

  // decode needs the full opcode: high byte is latched first, low byte is used from the read
  logic decoded;
  always_ff @(posedge clk) begin
    if (rst) begin
      font_base <= FONT_BASE_RST; seed <= SEED_RST; lfsr <= SEED_RST;
      ireg <= '0; pc <= PC_RST; sp <= '0; dt <= '0; st <= '0;
      row_ok <= '0; mop <= MOP_NONE; cnt <= '0; cnt_end <= '0;
      changed <= 1'b0; waiting <= 1'b0; fault <= 1'b0; hit <= 1'b0;
      decoded <= 1'b0;
      for (int r = 0; r < 16; r++) v[r] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FONT_BASE) font_base <= cfg_data;
        else begin
          seed <= (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
          lfsr <= (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
        end
      end
      if (accept) begin
        changed <= 1'b0; waiting <= 1'b0; fault <= 1'b0; hit <= 1'b0;
        cnt <= '0; decoded <= 1'b0; mop <= MOP_NONE;
      end
      if (cmd.decode) begin
        decoded <= 1'b1;
        cnt <= '0; cnt_end <= '0; mop <= MOP_NONE;
        pc <= pc2;
        unique case (op[15:12])
          4'h0: begin
            // clearing the valid bits clears the whole frame at once
            if ({op[11:8], mem_q} == OP_CLS) begin
              mop <= MOP_CLEAR;
              changed <= 1'b1;
            end else if ({op[11:8], mem_q} == OP_RET) begin
              if (sp == '0) fault <= 1'b1;
              else begin
                sp <= sp - SW'(1);
                pc <= rstack[SIW'(sp - SW'(1))];
              end
            end
          end
          4'h1: pc <= {op[11:8], mem_q};
          4'h2: begin
            if (sp >= SW'(STACK_DEPTH)) fault <= 1'b1;
            else begin
              rstack[SIW'(sp)] <= pc2;
              sp <= sp + SW'(1);
              pc <= {op[11:8], mem_q};
            end
          end
          4'h3: if (vx == mem_q) pc <= pc4;
          4'h4: if (vx != mem_q) pc <= pc4;
          4'h5: if (vx == v[mem_q[7:4]]) pc <= pc4;
          4'h6: v[op[11:8]] <= mem_q;
          4'h7: v[op[11:8]] <= vx + mem_q;
          4'h8: begin
            logic [8:0] s;
            logic [7:0] y8;
            y8 = v[mem_q[7:4]];
            s = {1'b0, vx} + {1'b0, y8};
            unique case (mem_q[3:0])
              4'h0: v[op[11:8]] <= y8;
              4'h1: v[op[11:8]] <= vx | y8;
              4'h2: v[op[11:8]] <= vx & y8;
              4'h3: v[op[11:8]] <= vx ^ y8;
              4'h4: begin v[15] <= {7'd0, s[8]}; v[op[11:8]] <= s[7:0]; end
              4'h5: begin v[15] <= {7'd0, vx >= y8}; v[op[11:8]] <= vx - y8; end
              4'h6: begin v[15] <= {7'd0, vx[0]}; v[op[11:8]] <= vx >> 1; end
              4'h7: begin v[15] <= {7'd0, y8 >= vx}; v[op[11:8]] <= y8 - vx; end
              4'hE: begin v[15] <= {7'd0, vx[7]}; v[op[11:8]] <= vx << 1; end
              default: ;
            endcase
          end
          4'h9: if (vx != v[mem_q[7:4]]) pc <= pc4;
          4'hA: ireg <= {op[11:8], mem_q};
          4'hB: pc <= {op[11:8], mem_q} + {4'd0, v[0]};
          4'hC: begin lfsr <= lfsr_step; v[op[11:8]] <= lfsr_step & mem_q; end
          4'hD: begin
            changed <= 1'b1;
            if (mem_q[3:0] == 4'd0) v[15] <= 8'd0;
            else begin mop <= MOP_DRAW; cnt_end <= mem_q[3:0] - 4'd1; end
          end
          4'hE: begin
            if ((mem_q == EX_SKIP_DOWN && keys_q[vx[3:0]]) ||
                (mem_q == EX_SKIP_UP && !keys_q[vx[3:0]])) pc <= pc4;
          end
          default: begin
            case (mem_q)
              FX_GET_DELAY: v[op[11:8]] <= dt;
              FX_KEY_WAIT: begin
                if (key_low[4]) begin pc <= pc; waiting <= 1'b1; end
                else v[op[11:8]] <= {4'd0, key_low[3:0]};
              end
              FX_SET_DELAY: dt <= vx;
              FX_SET_SOUND: st <= vx;
              FX_ADD_I: ireg <= ireg + {4'd0, vx};
              FX_FONT: ireg <= font_base + {4'd0, vx} + {2'd0, vx, 2'd0};
              FX_BCD: begin mop <= MOP_BCD; cnt_end <= 4'd2; end
              FX_STORE: begin mop <= MOP_STORE; cnt_end <= op[11:8]; end
              FX_LOAD: begin mop <= MOP_LOAD; cnt_end <= op[11:8]; end
              default: ;
            endcase
          end
        endcase
      end
      if (cmd.mem_use && mop == MOP_LOAD) begin
        v[cnt] <= mem_q;
        if (!status.last) cnt <= cnt + 4'd1;
      end
      if (cmd.draw_wr) begin
        if (row_ok_q && |(frame_q & spr_mask)) hit <= 1'b1;
        row_ok[frow] <= 1'b1;
        if (status.last) v[15] <= {7'd0, hit | (row_ok_q && |(frame_q & spr_mask))};
        else cnt <= cnt + 4'd1;
      end
      if (cmd.clear_step) begin
        row_ok <= '0;
        if (!status.last) cnt <= cnt + 4'd1;
      end
      if (cmd.mem_wr && !status.last) cnt <= cnt + 4'd1;
    end
  end

  // BCD digits of VX, constant divisors
  always_ff @(posedge clk) begin
    logic [7:0] h, t;
    if (cmd.decode) begin
      h = 8'((16'(vx) * 16'd41) >> 12);
      t = vx - 8'(h * 8'd100);
      bcd[0] <= h;
      bcd[1] <= 8'((16'(t) * 16'd205) >> 11);
      bcd[2] <= t - 8'(8'((16'(t) * 16'd205) >> 11) * 8'd10);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      program_counter <= pc;
      row_pixels <= '0;
      if (cmd_q == CMD_READ && 32'(row_q) < SCREEN_HEIGHT && row_ok_q) row_pixels <= frame_q;
      display_changed <= (cmd_q == CMD_EXEC) && changed;
      waiting_for_key <= (cmd_q == CMD_EXEC) && waiting;
      stack_fault <= (cmd_q == CMD_EXEC) && fault;
      delay_value <= dt;
      sound_value <= st;
    end
  end

  logic unused_ok;
  assign unused_ok = ^{seed, decoded, nn, nnn, oy, vy, VF_FLAG_BIT};

endmodule

/* rtl/chip8_instruction_core_unit.sv */
// chip8_instruction_core_unit: top level of the CHIP-8 core.
// Instantiates c8core_ctrl and c8core_dp; uses c8core_pkg.
`timescale 1ns / 1ps
// One command per start beat while busy is low; the result shows on done for one
// cycle and cannot be held off. Byte write and row read go from idle to done.
// Execute walks two memory fetch beats, decode, dispatch and result, plus a read,
// use and write step per sprite row on draws, a read and use step per register on
// FX65, a write step per byte on FX55/FX33, and a clear step on a clear. busy stays
// high through the done cycle, so the next start is taken in the cycle after it.
module chip8_instruction_core_unit import c8core_pkg::*; #(
  parameter int MEM_BYTES     = MEM_BYTES_DEF,
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [11:0] address,
  input  logic [7:0]  data,
  input  logic [4:0]  row_index,
  input  logic [15:0] key_mask,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output logic        done,
  output logic [11:0] program_counter,
  output logic [SCREEN_WIDTH-1:0] row_pixels,
  output logic        display_changed,
  output logic        waiting_for_key,
  output logic [7:0]  delay_value,
  output logic [7:0]  sound_value,
  output logic        stack_fault
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       accept;
  logic       ctl_busy;

  assign accept = start && !busy;

  c8core_ctrl u_ctrl (
    .clk, .rst,
    .go_exec(accept && command == CMD_EXEC),
    .go_simple(accept && command != CMD_EXEC),
    .status, .cmd, .busy(ctl_busy)
  );

  c8core_dp #(
    .MEM_BYTES(MEM_BYTES), .SCREEN_WIDTH(SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT), .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk, .rst, .accept, .command, .address, .data, .row_index, .key_mask,
    .cfg_we, .cfg_index, .cfg_data, .cmd, .status,
    .program_counter, .row_pixels, .display_changed, .waiting_for_key,
    .delay_value, .sound_value, .stack_fault
  );

  // result beat is registered from the finish step, in the cycle after it
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cmd.finish;
  end
  assign busy = ctl_busy || done;

`ifndef SYNTH
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> done) else $error("result beat missing");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !accept) else $error("accepted during result beat");
  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("controller issued two steps");
`endif

endmodule
